/* design/wmnlp_pkg.sv */
package wmnlp_pkg;

	localparam int unsigned VAL_BITS = 16;
	localparam int unsigned SCORE_BITS = 17;
	localparam int unsigned COUNT_OUT_BITS = 7;
	localparam logic [15:0] LN2_Q16 = 16'd45426;

	// Log2 mantissa table entries, computed by repeated squaring at elaboration.
	function automatic logic [15:0] mant_log2(input int unsigned k, input int unsigned tbits);
		logic [63:0] y;
		logic [15:0] r;
		y = (64'd1 << 30) + (64'(k) << (30 - tbits));
		r = '0;
		for (int b = 15; b >= 0; b--) begin
			y = (y * y) >> 30;
			if (y >= (64'd1 << 31)) begin
				y = y >> 1;
				r[b] = 1'b1;
			end
		end
		return r;
	endfunction

	typedef struct packed {
		logic clear;
		logic load;
		logic div_start;
		logic out_load;
	} wmnlp_cmd_t;

	typedef struct packed {
		logic div_done;
	} wmnlp_sts_t;

endpackage

/* design/wmnlp_ctrl.sv */
module wmnlp_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  new_contig,
	output logic                  in_ready,
	input  logic                  out_ready,
	output logic                  out_valid,
	input  wmnlp_pkg::wmnlp_sts_t sts,
	output wmnlp_pkg::wmnlp_cmd_t cmd
);
	import wmnlp_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOG  = 2'd1;
	localparam logic [1:0] ST_MUL  = 2'd2;
	localparam logic [1:0] ST_DIV  = 2'd3;

	logic [1:0] state_q;
	logic       out_valid_q;
	logic       take;

	// Output register lets a new item start while a result waits.
	assign in_ready = (state_q == ST_IDLE);
	assign take     = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.clear     = take && new_contig;
		cmd.load      = take;
		cmd.div_start = (state_q == ST_MUL);
		cmd.out_load  = (state_q == ST_DIV) && sts.div_done && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: if (take) state_q <= ST_LOG;
				ST_LOG:  state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_DIV;
				ST_DIV:  if (cmd.out_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end
endmodule

/* design/wmnlp_dp.sv */
module wmnlp_dp #(
	parameter int unsigned WINDOW = 101,
	parameter int unsigned POSITION_BITS = 21,
	parameter int unsigned LOG_TABLE_BITS = 6
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  wmnlp_pkg::wmnlp_cmd_t      cmd,
	output wmnlp_pkg::wmnlp_sts_t      sts,
	input  logic                       present,
	input  logic [15:0]                probability,
	output logic [POSITION_BITS-1:0]   position,
	output logic signed [16:0]         score,
	output logic [6:0]                 window_count
);
	import wmnlp_pkg::*;

	localparam int unsigned PTR_BITS = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int unsigned CNT_BITS = $clog2(WINDOW + 1);
	localparam int unsigned SUM_BITS = VAL_BITS + CNT_BITS;
	localparam int unsigned TSIZE = 1 << LOG_TABLE_BITS;
	localparam logic [PTR_BITS-1:0] LAST = PTR_BITS'(WINDOW - 1);

	logic [VAL_BITS-1:0] ring_val_q [WINDOW];
	logic [WINDOW-1:0]   ring_pres_q;
	logic [VAL_BITS-1:0] ev_val_q;
	logic [PTR_BITS-1:0] ptr_q, ev_ptr;
	logic [SUM_BITS-1:0] sum_q, sum_after;
	logic [CNT_BITS-1:0] cnt_q, cnt_after;
	logic [POSITION_BITS-1:0] pos_q, pos_s1;
	logic present_s1;
	logic [31:0] lq_s1;

	// log stage: leading one and table
	logic [15:0] p1, norm;
	logic [3:0]  e;
	logic [LOG_TABLE_BITS-1:0] k;
	logic [16:0] tab;
	always_comb begin
		p1 = (probability == 16'd0) ? 16'd1 : probability;
		e = 4'd0;
		for (int i = 1; i < 16; i++)
			if (p1[i]) e = 4'(i);
		norm = p1 << (4'd15 - e);
		k = norm[14 -: LOG_TABLE_BITS];
		tab = '0;
		for (int j = 0; j < TSIZE; j++)
			if (k == LOG_TABLE_BITS'(j)) tab = {1'b0, mant_log2(j, LOG_TABLE_BITS)};
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lq_s1      <= ({27'd0, 5'd16 - {1'b0, e}} << 16) - {15'd0, tab};
			present_s1 <= present;
			pos_s1     <= cmd.clear ? '0 : pos_q;
		end
	end

	// multiply stage
	logic [VAL_BITS-1:0] v_s2;
	logic [47:0] prod;
	assign prod = {16'd0, lq_s1} * {32'd0, LN2_Q16};

	assign ev_ptr    = (ptr_q == LAST) ? '0 : ptr_q + 1'b1;
	logic [SUM_BITS-1:0] sum_new;
	logic [CNT_BITS-1:0] cnt_new;
	assign sum_new = sum_q + SUM_BITS'(present_s1 ? v_s2 : '0);
	assign cnt_new = cnt_q + CNT_BITS'(present_s1);
	assign sum_after = ring_pres_q[ev_ptr]
		? ((sum_new >= SUM_BITS'(ev_val_q)) ? sum_new - SUM_BITS'(ev_val_q) : '0)
		: sum_new;
	assign cnt_after = (ring_pres_q[ev_ptr] && cnt_new != '0) ? cnt_new - 1'b1 : cnt_new;

	// divider: restoring, one quotient bit per cycle
	localparam int unsigned DIV_STEPS = SUM_BITS;
	logic [SUM_BITS-1:0] dvd_q, quo_q;
	logic [SUM_BITS:0]   rem_q, trial;
	logic [CNT_BITS-1:0] dvs_q, cnt_hold_q;
	logic [$clog2(DIV_STEPS+1)-1:0] step_q;
	logic busy_q, done_q, zero_q;
	assign trial = {rem_q[SUM_BITS-1:0], dvd_q[SUM_BITS-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0; sum_q <= '0; cnt_q <= '0; pos_q <= '0;
			ring_pres_q <= '0; busy_q <= 1'b0; done_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				ptr_q <= '0; sum_q <= '0; cnt_q <= '0; ring_pres_q <= '0;
			end
			if (cmd.load) begin
				pos_q <= (cmd.clear ? '0 : pos_q) + 1'b1;
				done_q <= 1'b0;
			end
			if (cmd.div_start) begin
				ring_pres_q[ptr_q] <= present_s1;
				ring_pres_q[ev_ptr] <= 1'b0;
				sum_q <= sum_after;
				cnt_q <= cnt_after;
				ptr_q <= ev_ptr;
				busy_q <= 1'b1;
				step_q <= '0;
				dvd_q <= sum_new + SUM_BITS'(cnt_new >> 1);
				dvs_q <= cnt_new;
				cnt_hold_q <= cnt_new;
				zero_q <= (cnt_new == '0);
				rem_q <= '0;
				quo_q <= sum_new;
			end else if (busy_q) begin
				if (zero_q || step_q == DIV_STEPS[$bits(step_q)-1:0]) begin
					busy_q <= 1'b0; done_q <= 1'b1;
				end else begin
					step_q <= step_q + 1'b1;
					dvd_q <= dvd_q << 1;
					if (trial >= {{(SUM_BITS+1-CNT_BITS){1'b0}}, dvs_q}) begin
						rem_q <= trial - {{(SUM_BITS+1-CNT_BITS){1'b0}}, dvs_q};
						quo_q <= {quo_q[SUM_BITS-2:0], 1'b1};
					end else begin
						rem_q <= trial;
						quo_q <= {quo_q[SUM_BITS-2:0], 1'b0};
					end
				end
			end
			if (cmd.out_load) done_q <= 1'b0;
		end
	end

	// oldest slot value is registered ahead of its use
	always_ff @(posedge clk) begin
		v_s2 <= VAL_BITS'((prod + 48'h80000) >> 20);
		ev_val_q <= ring_val_q[ev_ptr];
		if (cmd.div_start)
			ring_val_q[ptr_q] <= present_s1 ? v_s2 : '0;
		if (cmd.out_load) begin
			position     <= pos_s1;
			score        <= $signed(-SCORE_BITS'(quo_q));
			window_count <= COUNT_OUT_BITS'(cnt_hold_q);
		end
	end
	assign sts.div_done = done_q;
endmodule

/* design/windowed_mean_neg_log_prob.sv */
// Windowed mean of |ln p| along a contig.
// Input channel (in_valid/in_ready): new_contig, present, probability (Q0.16).
// Output channel (out_valid/out_ready): position, score (signed Q4.12, minus
// the rounded window mean), window_count.
// One result per item. The item is converted to |ln p| with a leading-one
// search and a log2 table and registered, multiplied by ln 2 in the next
// cycle, folded into the running sum, then divided by the count in a
// restoring divider that yields one quotient bit per cycle. The result is
// loaded when the divider finishes, which skips its steps when the window
// holds no present entry; the next item is taken only after the load, once
// the controller is idle again, so items do not overlap.
// new_contig clears the window, sum, count and position before the item.
// Reset clears control state and window valid bits; results then read empty.
// A stalled receiver holds the result in the output register and the block
// waits until it is taken before loading the next result.
module windowed_mean_neg_log_prob #(
	parameter int unsigned WINDOW = 101,
	parameter int unsigned POSITION_BITS = 21,
	parameter int unsigned LOG_TABLE_BITS = 6
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     new_contig,
	input  logic                     present,
	input  logic [15:0]              probability,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [POSITION_BITS-1:0] position,
	output logic signed [16:0]       score,
	output logic [6:0]               window_count
);
	import wmnlp_pkg::*;

	wmnlp_cmd_t cmd;
	wmnlp_sts_t sts;

	wmnlp_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .new_contig, .in_ready,
		.out_ready, .out_valid, .sts, .cmd
	);

	wmnlp_dp #(
		.WINDOW(WINDOW), .POSITION_BITS(POSITION_BITS), .LOG_TABLE_BITS(LOG_TABLE_BITS)
	) u_dp (
		.clk, .arst_n, .cmd, .sts, .present, .probability,
		.position, .score, .window_count
	);
endmodule

/* design/wmnlp_check.sv */
module wmnlp_check (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic signed [16:0] score,
	input logic [6:0]  window_count
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(score))
		else $error("result dropped");
	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> score <= 0)
		else $error("score positive");
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && window_count == 7'd0 |-> score == 17'sd0)
		else $error("empty window nonzero");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("two items in flight");
endmodule

bind windowed_mean_neg_log_prob wmnlp_check u_check (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .score, .window_count
);

/* verif/testbench.sv */
`timescale 1ns / 100ps

module testbench;

	// one predicted result per accepted item
	typedef struct {
		logic [20:0]        pos;
		logic signed [16:0] score;
		logic [6:0]         count;
	} window_result_t;

	// Tracks the sliding window of |ln p| values and queues the predicted results.
	class neg_log_scoreboard;
		localparam int unsigned SPAN = 101;
		bit        slot_present[SPAN];
		int unsigned slot_value[SPAN];
		int unsigned slot_ptr;
		int unsigned window_sum;
		int unsigned present_total;
		int unsigned next_pos;
		int unsigned log2_frac[64];
		window_result_t results_due[$];
		int unsigned mismatches;

		function new();
			longint unsigned y;
			for (int k = 0; k < 64; k++) begin
				y = (64'd1 << 30) + (longint'(k) << 24);
				log2_frac[k] = 0;
				for (int b = 15; b >= 0; b--) begin
					y = (y * y) >> 30;
					if (y >= (64'd1 << 31)) begin
						y = y >> 1;
						log2_frac[k] |= 1 << b;
					end
				end
			end
			mismatches = 0;
			clear_window();
		endfunction

		function void clear_window();
			for (int i = 0; i < SPAN; i++) begin
				slot_present[i] = 0;
				slot_value[i] = 0;
			end
			slot_ptr = 0;
			window_sum = 0;
			present_total = 0;
			next_pos = 0;
		endfunction

		// |ln p| in Q4.12, leading one plus 6-bit mantissa table
		function int unsigned neg_ln(logic [15:0] prob);
			int unsigned p, lead, frac_idx;
			longint unsigned lq16;
			p = (prob == 0) ? 1 : prob;
			lead = 15;
			while (lead > 0 && p[lead] == 0)
				lead--;
			frac_idx = ((p << (15 - lead)) & 16'hFFFF) >> 9;
			lq16 = ((16 - lead) << 16) - log2_frac[frac_idx & 63];
			return (lq16 * 45426 + (64'd1 << 19)) >> 20;
		endfunction

		function void note_position(logic new_contig, logic present, logic [15:0] prob);
			int unsigned v, mean, evict;
			window_result_t r;
			v = 0;
			if (new_contig)
				clear_window();
			if (present)
				v = neg_ln(prob);
			slot_present[slot_ptr] = present;
			slot_value[slot_ptr] = v;
			window_sum += v;
			if (present)
				present_total++;
			mean = (present_total > 0) ? (window_sum + present_total / 2) / present_total
				: window_sum;
			r.pos = next_pos[20:0];
			r.score = 17'(0 - mean);
			r.count = present_total[6:0];
			results_due = {results_due, r};
			// oldest entry leaves after this position's result
			evict = (slot_ptr + 1) % SPAN;
			if (slot_present[evict]) begin
				window_sum = (window_sum >= slot_value[evict]) ? window_sum - slot_value[evict] : 0;
				if (present_total > 0)
					present_total--;
			end
			slot_present[evict] = 0;
			slot_value[evict] = 0;
			slot_ptr = evict;
			next_pos = (next_pos + 1) & 21'h1FFFFF;
		endfunction

		function void check_result(logic [20:0] pos, logic signed [16:0] score, logic [6:0] count);
			window_result_t e;
			if (results_due.size() == 0) begin
				$display("%0t: unexpected result pos=%0d score=%0d count=%0d",
					$realtime, pos, score, count);
				mismatches++;
				return;
			end
			e = results_due.pop_front();
			if (pos !== e.pos) begin
				$display("%0t: position expected %0d got %0d", $realtime, e.pos, pos);
				mismatches++;
			end
			if (score !== e.score) begin
				$display("%0t: score expected %0d got %0d (pos %0d)", $realtime, e.score, score, e.pos);
				mismatches++;
			end
			if (count !== e.count) begin
				$display("%0t: window_count expected %0d got %0d (pos %0d)",
					$realtime, e.count, count, e.pos);
				mismatches++;
			end
		endfunction

		function int unsigned pending();
			return results_due.size();
		endfunction
	endclass

	localparam int unsigned WATCHDOG_LIMIT = 3000;
	localparam int unsigned DRAIN_CYCLES = 80;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               new_contig;
	logic               present;
	logic [15:0]        probability;
	logic               out_valid;
	logic               out_ready;
	logic [20:0]        position;
	logic signed [16:0] score;
	logic [6:0]         window_count;

	neg_log_scoreboard sb = new();

	// idle percentages per phase; hold_off forces a long receiver stall
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_off = 0;
	int unsigned quiet_cycles = 0;

	windowed_mean_neg_log_prob DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.new_contig(new_contig),
		.present(present),
		.probability(probability),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.position(position),
		.score(score),
		.window_count(window_count)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// monitor: both channels sampled at the rising edge, before any update lands
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_position(new_contig, present, probability);
			if (out_valid && out_ready)
				sb.check_result(position, score, window_count);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("testbench: done, errors");
				$finish;
			end
		end
	end

	// receiver: random stalls, or a counted hold-off when requested
	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else if (hold_off > 0) begin
			out_ready <= 1'b0;
			hold_off--;
		end else
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// offer one item and hold it until taken
	task automatic send_item(logic nc, logic pr, logic [15:0] prob);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		new_contig <= nc;
		present <= pr;
		probability <= prob;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// mostly well-formed stretches: long contigs, mostly present, varied magnitude
	task automatic send_random(int unsigned n);
		logic [15:0] prob;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(5))
				0: prob = 16'd0;
				1: prob = 16'hFFFF;
				2: prob = 16'($urandom_range(255));
				3: prob = 16'(1 << $urandom_range(15)) | 16'($urandom_range(1));
				default: prob = 16'($urandom);
			endcase
			send_item($urandom_range(199) == 0, $urandom_range(9) < 8, prob);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		new_contig = 1'b0;
		present = 1'b0;
		probability = 16'd0;
		out_ready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty window, probability extremes, every leading-one position
		send_item(1'b0, 1'b0, 16'hFFFF);
		send_item(1'b0, 1'b1, 16'd0);
		send_item(1'b0, 1'b1, 16'd1);
		send_item(1'b0, 1'b1, 16'hFFFF);
		send_item(1'b0, 1'b1, 16'h8000);
		for (int b = 1; b < 15; b++)
			send_item(1'b0, 1'b1, 16'((1 << b) | ((1 << b) - 1)));
		send_item(1'b1, 1'b0, 16'h1234);
		send_item(1'b1, 1'b1, 16'h0000);
		send_item(1'b0, 1'b0, 16'h0000);
		drain();

		// fill a full window of present entries so old ones start leaving
		for (int i = 0; i < 130; i++)
			send_item(1'b0, 1'b1, 16'($urandom_range(3)));

		send_random(440);
		drain();

		send_idle_pct = 54;
		send_random(470);
		drain();

		send_idle_pct = 0;
		recv_stall_pct = 54;
		send_random(200);
		// long receiver hold-off while items keep coming: input must back up
		hold_off = 400;
		send_random(270);
		drain();

		send_idle_pct = 16;
		recv_stall_pct = 16;
		send_random(300);
		drain();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_random(150);

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
